>>> rtl/core/cld_pkg.sv
// shared types, constants and helpers for the column run-length decoder
// no dependencies; used by the interfaces, cld_step and column_rle_decoder_unit
`default_nettype none

package cld_pkg;

  localparam int unsigned HeightW = 13;
  localparam int unsigned CountW  = 7;
  localparam int unsigned ByteW   = 8;

  localparam logic [HeightW-1:0] MaxColumnHeight   = 13'd4096;
  localparam logic [HeightW-1:0] ResetColumnHeight = 13'd64;

  localparam logic [ByteW-1:0]  RunFlagMask  = 8'h80;
  localparam logic [ByteW-1:0]  CountMask    = 8'h7f;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRunMode      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColumnHeight = 1'b1;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhColor   = 2'd1,
    PhLiteral = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [CountW-1:0]   pending;
    logic [HeightW-1:0]  pixels_left;
    logic                lit_over;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0]   pixel_value;
    logic [CountW-1:0]  run_length;
    logic               column_end;
    logic               overrun;
  } result_t;

  // clamp a written height into 1..MaxColumnHeight
  function automatic logic [HeightW-1:0] sat_height(input logic [HeightW-1:0] h);
    logic [HeightW-1:0] r;
    r = h;
    if (h == '0) r = {{(HeightW-1){1'b0}}, 1'b1};
    if (h > MaxColumnHeight) r = MaxColumnHeight;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cld_if.sv
// valid/ready channel interfaces for the column run-length decoder
// depends on cld_pkg for field widths
`default_nettype none

interface cld_code_if;
  logic                       valid;
  logic                       ready;
  logic [cld_pkg::ByteW-1:0]  code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface cld_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [cld_pkg::ByteW-1:0]   pixel_value;
  logic [cld_pkg::CountW-1:0]  run_length;
  logic                        column_end;
  logic                        overrun;

  modport source (output valid, output pixel_value, output run_length,
                  output column_end, output overrun, input ready);
  modport sink   (input valid, input pixel_value, input run_length,
                  input column_end, input overrun, output ready);
endinterface

interface cld_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cld_pkg::CfgIdxW-1:0]  reg_index;
  logic [cld_pkg::HeightW-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cld_step.sv
// decode of one code byte: next decoder state and the optional pixel word
// depends on cld_pkg
`default_nettype none

module cld_step (
  input  var cld_pkg::state_t              state_i,
  input  var logic                         run_mode_i,
  input  var logic [cld_pkg::HeightW-1:0]  height_i,
  input  var logic [cld_pkg::ByteW-1:0]    code_byte_i,
  output cld_pkg::state_t                  state_o,
  output logic                             res_valid_o,
  output cld_pkg::result_t                 res_o
);

  logic [cld_pkg::CountW-1:0]   cmd_count;
  logic [cld_pkg::CountW-1:0]   run_count;
  logic [cld_pkg::CountW-1:0]   emit_len;
  logic [cld_pkg::CountW-1:0]   clamp_len;
  logic                         cmd_over;
  logic                         emit_over;
  logic [cld_pkg::ByteW-1:0]    emit_value;
  logic [cld_pkg::HeightW-1:0]  left_after;
  logic                         col_end;
  logic [cld_pkg::CountW-1:0]   pending_dec;

  assign cmd_count = cld_pkg::CountW'(code_byte_i & cld_pkg::CountMask);

  // the pending run length applies in color phase, the byte's low seven bits otherwise
  assign run_count = (state_i.phase == cld_pkg::PhColor) ? state_i.pending : cmd_count;
  assign cmd_over  = {{(cld_pkg::HeightW-cld_pkg::CountW){1'b0}}, run_count}
                     > state_i.pixels_left;
  assign clamp_len = cmd_over ? state_i.pixels_left[cld_pkg::CountW-1:0] : run_count;

  // literal bytes are single pixels; a header only emits a transparent run of zeros
  assign emit_len   = (state_i.phase == cld_pkg::PhLiteral)
                      ? {{(cld_pkg::CountW-1){1'b0}}, 1'b1} : clamp_len;
  assign emit_over  = (state_i.phase == cld_pkg::PhLiteral) ? state_i.lit_over : cmd_over;
  assign emit_value = ((state_i.phase == cld_pkg::PhColor)
                       || (state_i.phase == cld_pkg::PhLiteral)) ? code_byte_i : '0;

  assign left_after = state_i.pixels_left
                      - {{(cld_pkg::HeightW-cld_pkg::CountW){1'b0}}, emit_len};
  assign col_end    = (left_after == '0);

  assign pending_dec = (state_i.pending != '0)
                       ? state_i.pending - {{(cld_pkg::CountW-1){1'b0}}, 1'b1}
                       : state_i.pending;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    case (state_i.phase)
      cld_pkg::PhColor: begin
        state_o.phase   = cld_pkg::PhHeader;
        state_o.pending = '0;
        res_valid_o     = (run_count != '0);
      end
      cld_pkg::PhLiteral: begin
        state_o.pending = pending_dec;
        if (pending_dec == '0) begin
          state_o.phase    = cld_pkg::PhHeader;
          state_o.lit_over = 1'b0;
        end
        res_valid_o = 1'b1;
      end
      default: begin
        state_o.phase = cld_pkg::PhHeader;
        if ((code_byte_i & cld_pkg::RunFlagMask) != '0) begin
          if (!run_mode_i) begin
            state_o.pending = cmd_count;
            state_o.phase   = cld_pkg::PhColor;
          end else begin
            // transparent run: value zero, no color byte
            res_valid_o = (cmd_count != '0);
          end
        end else if (code_byte_i != '0) begin
          // literal header: bit 7 clear so the byte is the count
          state_o.lit_over = cmd_over;
          state_o.pending  = clamp_len;
          state_o.phase    = cld_pkg::PhLiteral;
        end
      end
    endcase

    if (res_valid_o) begin
      state_o.pixels_left = col_end ? height_i : left_after;
    end

    res_o.pixel_value = emit_value;
    res_o.run_length  = emit_len;
    res_o.column_end  = col_end;
    res_o.overrun     = emit_over;
  end

endmodule

`default_nettype wire

>>> rtl/core/column_rle_decoder_unit.sv
// top level of the column run-length decoder: input register, decode, result register
// depends on cld_pkg, cld_if.sv interfaces and cld_step
`default_nettype none

// Decodes run-length coded texture columns, one code byte per word on code_i,
// into pixel words on pixel_o (value, run length, column end, overrun). A byte
// is accepted every cycle while the output side takes words; each byte is held
// in the input register and its decode is written to the result register, from
// which the pixel word is offered. While a waiting word is not taken the input
// register holds and code_i drops ready once it is full. Colored-run and literal
// headers and zero-length commands produce no word; a transparent-run header
// gives its word directly. Configuration on cfg_i is always ready: index 0 sets
// run_mode, index 1 sets column_height (clamped to 1..4096) and restarts the
// column; write it only while idle.
module column_rle_decoder_unit (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  cld_code_if.sink       code_i,
  cld_pixel_if.source    pixel_o,
  cld_cfg_if.sink        cfg_i
);

  logic                         in_valid_q;
  logic [cld_pkg::ByteW-1:0]    in_byte_q;
  logic                         out_valid_q;
  cld_pkg::result_t             out_q;
  cld_pkg::state_t              state_q;
  cld_pkg::state_t              state_d;
  logic                         run_mode_q;
  logic [cld_pkg::HeightW-1:0]  height_q;
  logic                         res_valid;
  cld_pkg::result_t             res;
  logic                         out_free;
  logic                         code_take;
  logic                         cfg_take;

  assign out_free  = !out_valid_q || pixel_o.ready;
  assign code_take = code_i.valid && code_i.ready;
  assign cfg_take  = cfg_i.valid && cfg_i.ready;

  assign code_i.ready = !in_valid_q || out_free;
  assign cfg_i.ready  = 1'b1;

  cld_step u_step (
    .state_i     (state_q),
    .run_mode_i  (run_mode_q),
    .height_i    (height_q),
    .code_byte_i (in_byte_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      run_mode_q           <= 1'b0;
      height_q             <= cld_pkg::ResetColumnHeight;
      state_q.phase        <= cld_pkg::PhHeader;
      state_q.pending      <= '0;
      state_q.pixels_left  <= cld_pkg::ResetColumnHeight;
      state_q.lit_over     <= 1'b0;
    end else begin
      if (code_take) begin
        in_valid_q <= 1'b1;
      end else if (out_free) begin
        in_valid_q <= 1'b0;
      end

      if (out_free) begin
        out_valid_q <= in_valid_q && res_valid;
      end

      if (cfg_take && (cfg_i.reg_index == cld_pkg::CfgColumnHeight)) begin
        // new height restarts the column and drops any pending command
        state_q.pixels_left <= cld_pkg::sat_height(cfg_i.wdata);
        state_q.phase       <= cld_pkg::PhHeader;
        state_q.pending     <= '0;
        state_q.lit_over    <= 1'b0;
      end else if (in_valid_q && out_free) begin
        state_q <= state_d;
      end

      if (cfg_take) begin
        case (cfg_i.reg_index)
          cld_pkg::CfgRunMode: begin
            run_mode_q <= cfg_i.wdata[0];
          end
          cld_pkg::CfgColumnHeight: begin
            height_q <= cld_pkg::sat_height(cfg_i.wdata);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_take) begin
      in_byte_q <= code_i.code_byte;
    end
    if (out_free && in_valid_q) begin
      out_q <= res;
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_value = out_q.pixel_value;
  assign pixel_o.run_length  = out_q.run_length;
  assign pixel_o.column_end  = out_q.column_end;
  assign pixel_o.overrun     = out_q.overrun;

endmodule

`default_nettype wire

>>> verif/column_rle_decoder_unit_tb.sv
// self-checking testbench for column_rle_decoder_unit: directed script, then random columns
// depends on cld_pkg and the cld_if.sv interfaces; predicts pixel words in a local decoder or takes hand-typed ones
`timescale 1ns / 1ps

module column_rle_decoder_unit_tb;
  import cld_pkg::*;

  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomWords = 1400;
  localparam int unsigned NumSteps    = 36;

  typedef enum logic [1:0] {
    StepByte   = 2'd0,
    StepMode   = 2'd1,
    StepHeight = 2'd2
  } step_e;

  // one script row: a code byte or a register write, optionally with a hand-typed result
  typedef struct packed {
    step_e              kind;
    logic [HeightW-1:0] arg;
    logic               typed;
    logic               has_px;
    result_t            px;
  } step_t;

  logic clk_i;
  logic rst_ni;

  cld_code_if  code_ch ();
  cld_pixel_if pixel_ch ();
  cld_cfg_if   cfg_ch ();

  column_rle_decoder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_ch),
    .pixel_o (pixel_ch),
    .cfg_i   (cfg_ch)
  );

  // decoder state kept by the testbench
  logic               mode_transparent;
  logic [HeightW-1:0] height_reg;
  phase_e             cur_phase;
  logic [CountW-1:0]  cmd_left;
  logic [HeightW-1:0] px_left;
  logic               lit_clamped;

  result_t pending_pixels [$];
  bit      steady;
  int      errors;
  int      sent_words;
  int      got_words;
  int      cfg_writes;
  int      seen_ends;
  int      seen_overruns;

  step_t script [0:NumSteps-1] = '{
    '{StepByte,   13'h000, 1'b1, 1'b0, '0},
    '{StepByte,   13'h080, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0FF, 1'b1, 1'b0, '0},
    '{StepByte,   13'h085, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0AB, 1'b1, 1'b1, '{8'hAB, 7'd5, 1'b0, 1'b0}},
    '{StepByte,   13'h002, 1'b0, 1'b0, '0},
    '{StepByte,   13'h000, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0FF, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0FF, 1'b0, 1'b0, '0},
    '{StepByte,   13'h011, 1'b1, 1'b1, '{8'h11, 7'd57, 1'b1, 1'b1}},
    '{StepHeight, 13'd3,   1'b0, 1'b0, '0},
    '{StepByte,   13'h005, 1'b0, 1'b0, '0},
    '{StepByte,   13'h012, 1'b1, 1'b1, '{8'h12, 7'd1, 1'b0, 1'b1}},
    '{StepByte,   13'h034, 1'b0, 1'b0, '0},
    '{StepByte,   13'h056, 1'b1, 1'b1, '{8'h56, 7'd1, 1'b1, 1'b1}},
    '{StepByte,   13'h080, 1'b0, 1'b0, '0},
    '{StepByte,   13'h000, 1'b1, 1'b0, '0},
    '{StepMode,   13'd1,   1'b0, 1'b0, '0},
    '{StepByte,   13'h081, 1'b1, 1'b1, '{8'h00, 7'd1, 1'b0, 1'b0}},
    '{StepByte,   13'h0FF, 1'b1, 1'b1, '{8'h00, 7'd2, 1'b1, 1'b1}},
    '{StepByte,   13'h080, 1'b1, 1'b0, '0},
    '{StepMode,   13'd0,   1'b0, 1'b0, '0},
    '{StepByte,   13'h082, 1'b0, 1'b0, '0},
    '{StepMode,   13'd1,   1'b0, 1'b0, '0},
    '{StepByte,   13'h077, 1'b0, 1'b0, '0},
    '{StepHeight, 13'd0,   1'b0, 1'b0, '0},
    '{StepMode,   13'd0,   1'b0, 1'b0, '0},
    '{StepByte,   13'h001, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0C3, 1'b1, 1'b1, '{8'hC3, 7'd1, 1'b1, 1'b0}},
    '{StepHeight, 13'h1FFF, 1'b0, 1'b0, '0},
    '{StepByte,   13'h0FF, 1'b0, 1'b0, '0},
    '{StepByte,   13'h000, 1'b1, 1'b1, '{8'h00, 7'd127, 1'b0, 1'b0}},
    '{StepByte,   13'h003, 1'b0, 1'b0, '0},
    '{StepHeight, 13'h1000, 1'b0, 1'b0, '0},
    '{StepByte,   13'h081, 1'b0, 1'b0, '0},
    '{StepByte,   13'h05A, 1'b0, 1'b0, '0}
  };

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [HeightW-1:0] usable_height();
    logic [HeightW-1:0] h;
    h = height_reg;
    if (h < 13'd1) h = 13'd1;
    if (h > 13'd4096) h = 13'd4096;
    return h;
  endfunction

  function automatic void place_pixels(input logic [ByteW-1:0] value,
                                       input logic [HeightW-1:0] len,
                                       input logic over, output result_t r);
    px_left = px_left - len;
    r.pixel_value = value;
    r.run_length  = len[CountW-1:0];
    r.column_end  = (px_left == '0);
    r.overrun     = over;
    if (px_left == '0) px_left = usable_height();
  endfunction

  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [HeightW-1:0] data);
    if (idx == CfgRunMode) begin
      mode_transparent = data[0];
    end else begin
      height_reg  = data;
      px_left     = usable_height();
      cur_phase   = PhHeader;
      cmd_left    = '0;
      lit_clamped = 1'b0;
    end
  endfunction

  // returns 1 when the byte completes a pixel word
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [HeightW-1:0] cnt;
    logic               over;
    bit                 made;
    made = 1'b0;
    r    = '0;
    case (cur_phase)
      PhColor: begin
        cur_phase = PhHeader;
        cnt       = {6'd0, cmd_left};
        cmd_left  = '0;
        if (cnt != '0) begin
          over = cnt > px_left;
          if (over) cnt = px_left;
          place_pixels(b, cnt, over, r);
          made = 1'b1;
        end
      end
      PhLiteral: begin
        over = lit_clamped;
        if (cmd_left != '0) cmd_left = cmd_left - {{(CountW-1){1'b0}}, 1'b1};
        if (cmd_left == '0) begin
          cur_phase   = PhHeader;
          lit_clamped = 1'b0;
        end
        place_pixels(b, 13'd1, over, r);
        made = 1'b1;
      end
      default: begin
        cur_phase = PhHeader;
        cnt       = {5'd0, b & CountMask};
        if ((b & RunFlagMask) != '0) begin
          if (!mode_transparent) begin
            cmd_left  = cnt[CountW-1:0];
            cur_phase = PhColor;
          end else if (cnt != '0) begin
            over = cnt > px_left;
            if (over) cnt = px_left;
            place_pixels(8'h00, cnt, over, r);
            made = 1'b1;
          end
        end else if (cnt != '0) begin
          lit_clamped = cnt > px_left;
          if (lit_clamped) cnt = px_left;
          cmd_left  = cnt[CountW-1:0];
          cur_phase = PhLiteral;
        end
      end
    endcase
    return made;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // starts and ends at a falling edge; valid stays high for a following word
  task automatic put_byte(input logic [ByteW-1:0] b, input logic typed,
                          input logic has_px, input result_t px);
    result_t r;
    bit      made;
    if (!steady && $urandom_range(99) < 6) begin
      code_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    code_ch.valid     <= 1'b1;
    code_ch.code_byte <= b;
    do @(posedge clk_i); while (!code_ch.ready);
    sent_words++;
    made = decode_byte(b, r);
    if (typed) begin
      if (has_px) pending_pixels.push_back(px);
    end else if (made) begin
      pending_pixels.push_back(r);
    end
    @(negedge clk_i);
  endtask

  task automatic send_code(input logic [ByteW-1:0] b);
    put_byte(b, 1'b0, 1'b0, '0);
  endtask

  // hold the sender until every pending pixel word is out and the pipeline is empty
  task automatic settle();
    code_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HeightW-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_setting(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [HeightW-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0: return 13'd0;
        1: return 13'd1;
        2: return 13'd4096;
        default: return 13'h1FFF;
      endcase
    end
    if (r < 20) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 80));
  endfunction

  function automatic int unsigned pick_count();
    if ($urandom_range(99) < 8) return $urandom_range(0, 127);
    return $urandom_range(0, 12);
  endfunction

  always @(negedge clk_i) begin
    pixel_ch.ready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin : watch_pixels
    result_t want;
    if (rst_ni && pixel_ch.valid && pixel_ch.ready) begin
      got_words++;
      if (pixel_ch.column_end) seen_ends++;
      if (pixel_ch.overrun) seen_overruns++;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected word value %h length %0d end %b overrun %b",
                                pixel_ch.pixel_value, pixel_ch.run_length,
                                pixel_ch.column_end, pixel_ch.overrun));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_ch.pixel_value !== want.pixel_value)
          note_mismatch($sformatf("pixel_value %h, want %h",
                                  pixel_ch.pixel_value, want.pixel_value));
        if (pixel_ch.run_length !== want.run_length)
          note_mismatch($sformatf("run_length %0d, want %0d",
                                  pixel_ch.run_length, want.run_length));
        if (pixel_ch.column_end !== want.column_end)
          note_mismatch($sformatf("column_end %b, want %b",
                                  pixel_ch.column_end, want.column_end));
        if (pixel_ch.overrun !== want.overrun)
          note_mismatch($sformatf("overrun %b, want %b", pixel_ch.overrun, want.overrun));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned burst;
    int unsigned len;
    int unsigned pick;
    int          round;
    logic [ByteW-1:0] hdr;
    rst_ni            = 1'b0;
    code_ch.valid     = 1'b0;
    code_ch.code_byte = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.wdata      = '0;
    steady            = 1'b0;
    mode_transparent  = 1'b0;
    height_reg        = ResetColumnHeight;
    cur_phase         = PhHeader;
    cmd_left          = '0;
    px_left           = ResetColumnHeight;
    lit_clamped       = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumSteps; i++) begin
      case (script[i].kind)
        StepByte: put_byte(script[i].arg[ByteW-1:0], script[i].typed,
                           script[i].has_px, script[i].px);
        StepMode: begin
          settle();
          write_reg(CfgRunMode, script[i].arg);
        end
        default: begin
          settle();
          write_reg(CfgColumnHeight, script[i].arg);
        end
      endcase
    end

    round = 0;
    while (sent_words < NumSteps + RandomWords) begin
      settle();
      pick = $urandom_range(3);
      if (pick[0]) write_reg(CfgRunMode, 13'($urandom_range(1)));
      if (pick[1]) write_reg(CfgColumnHeight, pick_height());
      // a few rounds with neither side idling
      steady = (round >= 4 && round < 8);
      burst  = $urandom_range(5, 20);
      for (int c = 0; c < burst; c++) begin
        pick = $urandom_range(99);
        len  = pick_count();
        if (pick < 45) begin
          hdr = RunFlagMask | 8'(len);
          send_code(hdr);
          if (!mode_transparent) send_code(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
          send_code(8'(len) & CountMask);
          for (int k = 0; k < int'(len & 32'h7f); k++) send_code(8'($urandom_range(0, 255)));
        end else begin
          send_code(8'($urandom_range(0, 255)));
        end
      end
      round++;
    end
    steady = 1'b0;
    settle();
    repeat (2 * DrainCycles) @(negedge clk_i);

    $display("sent %0d code words in %0d random rounds with %0d register writes",
             sent_words, round, cfg_writes);
    $display("checked %0d pixel words: %0d column ends, %0d overruns",
             got_words, seen_ends, seen_overruns);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> column_rle_decoder_unit.f
rtl/core/cld_pkg.sv
rtl/core/cld_if.sv
rtl/core/cld_step.sv
rtl/core/column_rle_decoder_unit.sv
verif/column_rle_decoder_unit_tb.sv
